// File: src/sldisp_pkg.sv
`default_nettype none

package sldisp_pkg;

  localparam int DEF_NUM_SERVERS  = 5;
  localparam int DEF_COUNT_WIDTH  = 8;
  localparam int DEF_TOTAL_WIDTH  = 32;
  localparam int DEF_RANDOM_WIDTH = 16;

  localparam int AMOUNT_W    = 16;
  localparam int LIMIT_W     = 8;
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 8;

  localparam logic [LIMIT_W-1:0] QUEUE_LIMIT_RESET = LIMIT_W'(100);

  typedef enum logic {
    OP_ARRIVE = 1'b0,
    OP_DEPART = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    POL_ROUND_ROBIN    = 2'd0,
    POL_RANDOM         = 2'd1,
    POL_SHORTEST       = 2'd2,
    POL_SHORTEST_LEAST = 2'd3
  } policy_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_POLICY      = 1'd0,
    REG_QUEUE_LIMIT = 1'd1
  } reg_index_t;

endpackage

`default_nettype wire

// File: src/server_load_balancer_dispatch_unit.sv
// An arrival beat is registered in stage s1 and its result then in the output registers.
// One beat per cycle unless out_stall blocks an arrival; the single-pass compare and update
// stage sets that rate. A departure beat updates the job counts and produces no result.
// Synchronous reset clears the job counts, service totals and the rotation pointer, selects
// round robin and sets the queue limit to 100.
`default_nettype none

module server_load_balancer_dispatch_unit #(
  parameter int NUM_SERVERS  = sldisp_pkg::DEF_NUM_SERVERS,
  parameter int COUNT_WIDTH  = sldisp_pkg::DEF_COUNT_WIDTH,
  parameter int TOTAL_WIDTH  = sldisp_pkg::DEF_TOTAL_WIDTH,
  parameter int RANDOM_WIDTH = sldisp_pkg::DEF_RANDOM_WIDTH
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_wr_en,
  input  logic [sldisp_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [sldisp_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic                                  operation,
  input  logic [$clog2(NUM_SERVERS)-1:0]        server_index,
  input  logic [sldisp_pkg::AMOUNT_W-1:0]       service_amount,
  input  logic [RANDOM_WIDTH-1:0]               random_value,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [$clog2(NUM_SERVERS)-1:0]        chosen_server,
  output logic [COUNT_WIDTH-1:0]                depth_after,
  output logic                                  limit_exceeded
);

  import sldisp_pkg::*;

  localparam int IDX_W = $clog2(NUM_SERVERS);
  localparam int CNT_W = $clog2(NUM_SERVERS + 1);
  localparam int PROD_W = RANDOM_WIDTH + CNT_W;
  localparam int CMP_W = (COUNT_WIDTH > LIMIT_W) ? COUNT_WIDTH : LIMIT_W;
  localparam logic [IDX_W-1:0] LAST_SERVER = IDX_W'(NUM_SERVERS - 1);
  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;
  localparam logic [TOTAL_WIDTH-1:0] TOTAL_MAX = '1;

  policy_t                 policy;
  logic [LIMIT_W-1:0]      queue_limit;
  logic [COUNT_WIDTH-1:0]  job_count [NUM_SERVERS];
  logic [TOTAL_WIDTH-1:0]  service_total [NUM_SERVERS];
  logic [IDX_W-1:0]        rotation_pointer;
  logic [IDX_W-1:0]        rotation_pointer_next;

  logic                    s1_valid;
  op_t                     s1_op;
  logic [IDX_W-1:0]        s1_index;
  logic [AMOUNT_W-1:0]     s1_amount;
  logic [RANDOM_WIDTH-1:0] s1_random;
  logic                    s1_go;
  logic                    s1_arrive;
  logic                    in_accept;

  logic [NUM_SERVERS-1:0]  short_mask;
  logic [NUM_SERVERS-1:0]  least_mask;
  logic [NUM_SERVERS-1:0]  cand_mask;
  logic [CNT_W-1:0]        cand_cnt;
  logic [PROD_W-1:0]       pick_prod;
  logic [CNT_W-1:0]        pick_rank;
  logic [IDX_W-1:0]        rand_sel;
  logic [IDX_W-1:0]        rr_sel;
  logic [IDX_W-1:0]        sel;

  logic [COUNT_WIDTH-1:0]  count_upd [NUM_SERVERS];
  logic [TOTAL_WIDTH-1:0]  total_upd [NUM_SERVERS];
  logic                    flag;

  assign in_stall  = s1_valid && !s1_go;
  assign in_accept = in_valid && !in_stall;
  assign s1_arrive = (s1_op == OP_ARRIVE);
  assign s1_go     = s1_valid && (!s1_arrive || !out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      policy      <= POL_ROUND_ROBIN;
      queue_limit <= QUEUE_LIMIT_RESET;
    end else if (cfg_wr_en) begin
      case (reg_index_t'(cfg_index))
        REG_POLICY:      policy <= policy_t'(cfg_data[1:0]);
        REG_QUEUE_LIMIT: queue_limit <= cfg_data[LIMIT_W-1:0];
        default:         ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_accept) begin
      s1_valid <= 1'b1;
    end else if (s1_go) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_op     <= op_t'(operation);
      s1_index  <= server_index;
      s1_amount <= service_amount;
      s1_random <= random_value;
    end
  end

  always_comb begin
    for (int i = 0; i < NUM_SERVERS; i++) begin
      short_mask[i] = 1'b1;
      for (int j = 0; j < NUM_SERVERS; j++) begin
        if (job_count[j] < job_count[i]) begin
          short_mask[i] = 1'b0;
        end
      end
    end
  end

  always_comb begin
    for (int i = 0; i < NUM_SERVERS; i++) begin
      least_mask[i] = short_mask[i];
      for (int j = 0; j < NUM_SERVERS; j++) begin
        if (short_mask[j] && (service_total[j] < service_total[i])) begin
          least_mask[i] = 1'b0;
        end
      end
    end
  end

  always_comb begin
    case (policy)
      POL_SHORTEST:       cand_mask = short_mask;
      POL_SHORTEST_LEAST: cand_mask = least_mask;
      default:            cand_mask = '1;
    endcase
  end

  assign cand_cnt  = CNT_W'($countones(cand_mask));
  assign pick_prod = PROD_W'(s1_random) * PROD_W'(cand_cnt);
  assign pick_rank = pick_prod[RANDOM_WIDTH +: CNT_W];

  always_comb begin
    logic [NUM_SERVERS-1:0] below;
    rand_sel = '0;
    for (int i = 0; i < NUM_SERVERS; i++) begin
      for (int j = 0; j < NUM_SERVERS; j++) begin
        below[j] = (j < i) && cand_mask[j];
      end
      if (cand_mask[i] && (CNT_W'($countones(below)) == pick_rank)) begin
        rand_sel = IDX_W'(i);
      end
    end
  end

  always_comb begin
    if (rotation_pointer >= LAST_SERVER) begin
      rr_sel                = LAST_SERVER;
      rotation_pointer_next = '0;
    end else begin
      rr_sel                = rotation_pointer;
      rotation_pointer_next = rotation_pointer + IDX_W'(1);
    end
  end

  assign sel = (policy == POL_ROUND_ROBIN) ? rr_sel : rand_sel;

  always_comb begin
    logic [TOTAL_WIDTH:0] sum;
    flag = 1'b0;
    for (int i = 0; i < NUM_SERVERS; i++) begin
      count_upd[i] = job_count[i];
      total_upd[i] = service_total[i];
      sum = {1'b0, service_total[i]} + (TOTAL_WIDTH + 1)'(s1_amount);
      if (s1_arrive && (sel == IDX_W'(i))) begin
        if (job_count[i] != COUNT_MAX) begin
          count_upd[i] = job_count[i] + COUNT_WIDTH'(1);
        end
        total_upd[i] = sum[TOTAL_WIDTH] ? TOTAL_MAX : sum[TOTAL_WIDTH-1:0];
      end
      if (!s1_arrive && (s1_index == IDX_W'(i)) && (job_count[i] != '0)) begin
        count_upd[i] = job_count[i] - COUNT_WIDTH'(1);
      end
      if (CMP_W'(count_upd[i]) > CMP_W'(queue_limit)) begin
        flag = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rotation_pointer <= '0;
      for (int i = 0; i < NUM_SERVERS; i++) begin
        job_count[i]     <= '0;
        service_total[i] <= '0;
      end
    end else if (s1_go) begin
      for (int i = 0; i < NUM_SERVERS; i++) begin
        job_count[i]     <= count_upd[i];
        service_total[i] <= total_upd[i];
      end
      if (s1_arrive && (policy == POL_ROUND_ROBIN)) begin
        rotation_pointer <= rotation_pointer_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_go && s1_arrive) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_arrive) begin
      chosen_server  <= sel;
      depth_after    <= count_upd[sel];
      limit_exceeded <= flag;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (chosen_server <= LAST_SERVER))
    else $error("chosen server out of range");

  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (depth_after != '0))
    else $error("dispatched server shows an empty queue");

  assert property (@(posedge clk) disable iff (rst)
    rotation_pointer <= LAST_SERVER)
    else $error("rotation pointer out of range");

  assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s1_arrive && !out_stall) |=> !out_valid)
    else $error("departure beat produced a result");

  assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (s1_valid && s1_arrive && out_valid && out_stall))
    else $error("input stalled without a blocked result");

endmodule

`default_nettype wire
